>>> sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rstn, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (con)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (con)) \
        else $error("assertion failed");

`endif

>>> sv/bsa_pkg.sv
// Types and constants of the banker's safe allocator.
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int W_UNIT = 8;
    localparam int W_NEED = 9;
    localparam int W_REM  = 13;

    localparam logic [1:0] OP_SET_AVAIL = 2'd0;
    localparam logic [1:0] OP_SET_CLAIM = 2'd1;
    localparam logic [1:0] OP_SET_ALLOC = 2'd2;
    localparam logic [1:0] OP_REQUEST   = 2'd3;

    localparam logic [1:0] ST_LOAD    = 2'd0;
    localparam logic [1:0] ST_SAFE    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_UNSAFE  = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [3:0]        process;
        logic [1:0]        resource;
        logic signed [7:0] amount_0;
        logic signed [7:0] amount_1;
        logic signed [7:0] amount_2;
        logic signed [7:0] amount_3;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic       granted;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CK_RD,
        S_CK_EV,
        S_FIN
    } t_state;

endpackage

>>> sv/bsa_row_ram.sv
// Row memory with registered read and per-row valid bits that read as zero.
`timescale 1ns / 1ps

module bsa_row_ram #(
    parameter int DEPTH = 5,
    parameter int WIDTH = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    // write the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // track written rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // register the read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata  <= mem[i_raddr];
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

>>> sv/bankers_safe_allocator.sv
// Banker's algorithm allocator: top level with request check and safety sequencer.
// Loads and rejected requests are decided in S_EXEC, held there until the result slot is free.
// A checked request scans k entries, up to N*N with N processes; each entry is the single
// claim/allocation row read followed by its evaluation.
// One transaction is in work at a time; a waiting result does not block acceptance.
// Synchronous active-low reset clears control, available vector and the row valid bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bankers_safe_allocator
    import bsa_pkg::*;
#(
    parameter int NUM_PROCESSES = 5,
    parameter int NUM_RESOURCES = 3
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int PW    = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int CW    = $clog2(NUM_PROCESSES + 1);
    localparam int ROW_W = W_UNIT * NUM_RESOURCES;

    t_state r_state, n_state;

    t_in                      r_req;
    logic signed [W_UNIT-1:0] r_avail     [NUM_RESOURCES];
    logic signed [W_UNIT-1:0] r_avail_new [NUM_RESOURCES];
    logic signed [W_REM-1:0]  r_rem       [NUM_RESOURCES];
    logic [ROW_W-1:0]         r_tent;
    logic [NUM_PROCESSES-1:0] r_done;
    logic [CW-1:0]            r_p;
    logic [CW-1:0]            r_fin;
    logic                     r_prog;
    logic                     r_safe;
    logic                     r_out_valid;
    t_out                     r_out;

    logic signed [W_UNIT-1:0] amt [4];
    logic [ROW_W-1:0]         claim_row, alloc_row, alloc_eff, load_row, tent_row;
    logic                     slot_free, accept, bad, proc_ok, fits, fin_all, last_p;
    logic [CW-1:0]            fin_n;

    logic                     ram_re, claim_we, alloc_we, emit;
    logic [PW-1:0]            ram_raddr;
    logic [ROW_W-1:0]         ram_wdata;
    logic [1:0]               emit_status;

    assign amt[0] = r_req.amount_0;
    assign amt[1] = r_req.amount_1;
    assign amt[2] = r_req.amount_2;
    assign amt[3] = r_req.amount_3;

    assign slot_free = !r_out_valid || i_out_ready;
    assign accept    = i_in_valid && o_in_ready;
    assign proc_ok   = {1'b0, r_req.process} < 5'(NUM_PROCESSES);

    bsa_row_ram #(.DEPTH(NUM_PROCESSES), .WIDTH(ROW_W)) u_claim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .i_we    (claim_we),
        .i_waddr (r_req.process[PW-1:0]),
        .i_wdata (ram_wdata),
        .o_rdata (claim_row)
    );

    bsa_row_ram #(.DEPTH(NUM_PROCESSES), .WIDTH(ROW_W)) u_alloc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .i_we    (alloc_we),
        .i_waddr (r_req.process[PW-1:0]),
        .i_wdata (ram_wdata),
        .o_rdata (alloc_row)
    );

    // validate the request and form tentative and loaded rows
    always_comb begin
        logic signed [W_UNIT-1:0] c, a;
        logic signed [W_NEED-1:0] sum;
        bad      = 1'b0;
        tent_row = alloc_row;
        load_row = (r_req.opcode == OP_SET_CLAIM) ? claim_row : alloc_row;
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            c   = claim_row[r*W_UNIT +: W_UNIT];
            a   = alloc_row[r*W_UNIT +: W_UNIT];
            sum = W_NEED'(a) + W_NEED'(amt[r]);
            if (amt[r] < 0 || sum > W_NEED'(c) || r_avail[r] < amt[r]) begin
                bad = 1'b1;
            end
            tent_row[r*W_UNIT +: W_UNIT] = sum[W_UNIT-1:0];
            if ({2'b0, r_req.resource} == 4'(r)) begin
                load_row[r*W_UNIT +: W_UNIT] = amt[0];
            end
        end
    end

    // evaluate one entry of the safety scan
    always_comb begin
        logic signed [W_UNIT-1:0] c, a;
        logic signed [W_NEED-1:0] need;
        alloc_eff = (r_p[PW-1:0] == r_req.process[PW-1:0]) ? r_tent : alloc_row;
        fits      = !r_done[r_p[PW-1:0]];
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            c    = claim_row[r*W_UNIT +: W_UNIT];
            a    = alloc_eff[r*W_UNIT +: W_UNIT];
            need = W_NEED'(c) - W_NEED'(a);
            if (W_REM'(need) > r_rem[r]) begin
                fits = 1'b0;
            end
        end
        fin_n   = r_fin + CW'(fits);
        fin_all = fin_n == CW'(NUM_PROCESSES);
        last_p  = r_p == CW'(NUM_PROCESSES - 1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_req.opcode == OP_REQUEST && proc_ok && !bad) begin
                    n_state = S_CK_RD;
                end else if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CK_RD: n_state = S_CK_EV;
            S_CK_EV: begin
                if (fin_all || (last_p && !(r_prog || fits))) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CK_RD;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_in_ready  = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = i_in.process[PW-1:0];
        claim_we    = 1'b0;
        alloc_we    = 1'b0;
        ram_wdata   = load_row;
        emit        = 1'b0;
        emit_status = ST_LOAD;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                ram_re     = accept;
            end
            S_EXEC: begin
                if (r_req.opcode == OP_REQUEST) begin
                    if (!proc_ok || bad) begin
                        emit        = slot_free;
                        emit_status = ST_INVALID;
                    end
                end else begin
                    emit = slot_free;
                    if (proc_ok && {2'b0, r_req.resource} < 4'(NUM_RESOURCES)) begin
                        claim_we = slot_free && r_req.opcode == OP_SET_CLAIM;
                        alloc_we = slot_free && r_req.opcode == OP_SET_ALLOC;
                    end
                end
            end
            S_CK_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_p[PW-1:0];
            end
            S_FIN: begin
                emit        = slot_free;
                emit_status = r_safe ? ST_SAFE : ST_UNSAFE;
                alloc_we    = slot_free && r_safe;
                ram_wdata   = r_tent;
            end
            default: ;
        endcase
    end

    // advance state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int r = 0; r < NUM_RESOURCES; r++) begin
                r_avail[r] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid   <= 1'b1;
                r_out.status  <= emit_status;
                r_out.granted <= emit_status == ST_SAFE;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EXEC && r_req.opcode == OP_SET_AVAIL && slot_free) begin
                for (int r = 0; r < NUM_RESOURCES; r++) begin
                    if ({2'b0, r_req.resource} == 4'(r)) begin
                        r_avail[r] <= amt[0];
                    end
                end
            end
            if (r_state == S_FIN && slot_free && r_safe) begin
                r_avail <= r_avail_new;
            end
        end
    end

    // hold the transaction and run the scan datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_p    <= '0;
            r_fin  <= '0;
            r_prog <= 1'b0;
            r_safe <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req <= i_in;
                    end
                end
                S_EXEC: begin
                    r_tent <= tent_row;
                    for (int r = 0; r < NUM_RESOURCES; r++) begin
                        r_avail_new[r] <= r_avail[r] - amt[r];
                        r_rem[r]       <= W_REM'(r_avail[r]) - W_REM'(amt[r]);
                    end
                    r_done <= '0;
                    r_p    <= '0;
                    r_fin  <= '0;
                    r_prog <= 1'b0;
                end
                S_CK_EV: begin
                    if (fits) begin
                        r_done[r_p[PW-1:0]] <= 1'b1;
                        for (int r = 0; r < NUM_RESOURCES; r++) begin
                            r_rem[r] <= r_rem[r] + W_REM'($signed(alloc_eff[r*W_UNIT +: W_UNIT]));
                        end
                    end
                    r_fin <= fin_n;
                    if (fin_all) begin
                        r_safe <= 1'b1;
                    end else if (last_p) begin
                        r_safe <= 1'b0;
                        r_p    <= '0;
                        r_prog <= 1'b0;
                    end else begin
                        r_p    <= r_p + 1'b1;
                        r_prog <= r_prog || fits;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_IMPL(a_grant_status, i_clk, i_rst_n, o_out_valid, o_out.granted == (o_out.status == ST_SAFE))
    `ASSERT_IMPL(a_fin_bound, i_clk, i_rst_n, 1'b1, r_fin <= CW'(NUM_PROCESSES))
    `ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_EXEC)

endmodule

>>> dv/tb_bankers_safe_allocator.sv
// Self-checking testbench for the banker's safe allocator: directed and random transactions.
`timescale 1ns / 1ps

module tb_bankers_safe_allocator;
    import bsa_pkg::*;

    localparam int NPROC = 5;
    localparam int NRES  = 3;
    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    bankers_safe_allocator #(.NUM_PROCESSES(NPROC), .NUM_RESOURCES(NRES)) dut (.*);

    always #5 i_clk = ~i_clk;

    // Predicted allocator state
    int avail_q[NRES];
    int claim_q[NPROC][NRES];
    int alloc_q[NPROC][NRES];

    t_out expected_status_q[$];
    int   error_count = 0;
    int   cycle_count = 0;
    int   burst_left = 0;

    // Run the safety pass over the predicted tables
    function automatic bit state_is_safe();
        int  rem[NRES];
        bit  done[NPROC];
        int  finished;
        bit  progress;
        bit  fits;
        finished = 0;
        for (int r = 0; r < NRES; r++) rem[r] = avail_q[r];
        for (int p = 0; p < NPROC; p++) done[p] = 1'b0;
        while (finished < NPROC) begin
            progress = 1'b0;
            for (int p = 0; p < NPROC; p++) begin
                if (!done[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < NRES; r++)
                        if (claim_q[p][r] - alloc_q[p][r] > rem[r]) fits = 1'b0;
                    if (fits) begin
                        for (int r = 0; r < NRES; r++) rem[r] += alloc_q[p][r];
                        done[p] = 1'b1;
                        finished++;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Update the predicted state and return the expected result of one transaction
    function automatic t_out predict_allocation(t_in t);
        t_out o;
        int   amt[4];
        bit   bad;
        o = '0;
        amt[0] = t.amount_0; amt[1] = t.amount_1;
        amt[2] = t.amount_2; amt[3] = t.amount_3;
        o.status = ST_LOAD;
        case (t.opcode)
            OP_SET_AVAIL: begin
                if (t.resource < NRES) avail_q[t.resource] = amt[0];
            end
            OP_SET_CLAIM: begin
                if (t.process < NPROC && t.resource < NRES)
                    claim_q[t.process][t.resource] = amt[0];
            end
            OP_SET_ALLOC: begin
                if (t.process < NPROC && t.resource < NRES)
                    alloc_q[t.process][t.resource] = amt[0];
            end
            default: begin
                bad = (t.process >= NPROC);
                if (!bad)
                    for (int r = 0; r < NRES; r++)
                        if (amt[r] < 0 || alloc_q[t.process][r] + amt[r] > claim_q[t.process][r]
                            || avail_q[r] < amt[r]) bad = 1'b1;
                if (bad) begin
                    o.status = ST_INVALID;
                end else begin
                    for (int r = 0; r < NRES; r++) begin
                        avail_q[r] -= amt[r];
                        alloc_q[t.process][r] += amt[r];
                    end
                    if (state_is_safe()) begin
                        o.status = ST_SAFE;
                        o.granted = 1'b1;
                    end else begin
                        for (int r = 0; r < NRES; r++) begin
                            avail_q[r] += amt[r];
                            alloc_q[t.process][r] -= amt[r];
                        end
                        o.status = ST_UNSAFE;
                    end
                end
            end
        endcase
        return o;
    endfunction

    // Send one transaction, with bursty gaps; returns at the falling edge after acceptance
    task automatic send_item(t_in t);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in <= t;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_status_q.push_back(predict_allocation(t));
        @(negedge i_clk);
    endtask

    function automatic t_in make_item(logic [1:0] op, int proc, int res,
                                      int a0, int a1 = 0, int a2 = 0, int a3 = 0);
        t_in t;
        t.opcode = op; t.process = 4'(proc); t.resource = 2'(res);
        t.amount_0 = 8'(a0); t.amount_1 = 8'(a1);
        t.amount_2 = 8'(a2); t.amount_3 = 8'(a3);
        return t;
    endfunction

    // Check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_status_q.size() == 0) begin
                $error("unexpected result status=%0d granted=%0d", o_out.status, o_out.granted);
                error_count++;
            end else begin
                t_out e;
                e = expected_status_q.pop_front();
                if (o_out.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_out.status);
                    error_count++;
                end
                if (o_out.granted !== e.granted) begin
                    $error("granted expected %0d actual %0d", e.granted, o_out.granted);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern: open stretches alternate with stretches of random stalls
    always @(negedge i_clk) begin
        if (cycle_count % 200 < 60) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic load_system(int lo, int hi);
        for (int r = 0; r < NRES; r++)
            send_item(make_item(OP_SET_AVAIL, 0, r, $urandom_range(lo, hi)));
        for (int p = 0; p < NPROC; p++)
            for (int r = 0; r < NRES; r++) begin
                int c;
                c = $urandom_range(lo, hi);
                send_item(make_item(OP_SET_CLAIM, p, r, c));
                send_item(make_item(OP_SET_ALLOC, p, r, $urandom_range(0, c)));
            end
    endtask

    // Extremes, range errors and a textbook safe/unsafe case
    task automatic test_directed();
        send_item(make_item(OP_SET_AVAIL, 0, 3, 127));
        send_item(make_item(OP_SET_CLAIM, 15, 0, -128));
        send_item(make_item(OP_SET_ALLOC, 5, 3, 55));
        send_item(make_item(OP_REQUEST, 15, 0, 0));
        send_item(make_item(OP_REQUEST, 0, 0, 0, 0, 0, -1));
        send_item(make_item(OP_REQUEST, 0, 0, -128, 0, 0));
        send_item(make_item(OP_SET_AVAIL, 0, 0, 3));
        send_item(make_item(OP_SET_AVAIL, 0, 1, 3));
        send_item(make_item(OP_SET_AVAIL, 0, 2, 2));
        send_item(make_item(OP_SET_CLAIM, 1, 0, 3));
        send_item(make_item(OP_SET_CLAIM, 1, 1, 2));
        send_item(make_item(OP_SET_CLAIM, 1, 2, 2));
        send_item(make_item(OP_SET_CLAIM, 0, 0, 7));
        send_item(make_item(OP_SET_CLAIM, 0, 1, 5));
        send_item(make_item(OP_SET_CLAIM, 0, 2, 3));
        send_item(make_item(OP_REQUEST, 1, 0, 1, 0, 2, 127));
        send_item(make_item(OP_REQUEST, 0, 0, 3, 3, 0));
        send_item(make_item(OP_REQUEST, 0, 0, 4, 0, 0));
        send_item(make_item(OP_REQUEST, 1, 0, 2, 2, 0));
        send_item(make_item(OP_SET_CLAIM, 4, 2, -128));
        send_item(make_item(OP_SET_ALLOC, 4, 1, 127));
        send_item(make_item(OP_REQUEST, 2, 0, 0, 0, 0, -128));
    endtask

    // Random loads and requests, mostly well-formed scenarios
    task automatic test_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // Raw noise across all field bits
                t_in         t;
                logic [63:0] raw;
                raw = {$urandom, $urandom};
                t = t_in'(raw[$bits(t_in)-1:0]);
                send_item(t);
                sent++;
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    load_system(0, 10);
                    sent += NRES + 2 * NPROC * NRES;
                end
                repeat ($urandom_range(3, 10)) begin
                    send_item(make_item(OP_REQUEST, $urandom_range(0, NPROC), 0,
                        $urandom_range(0, 4), $urandom_range(0, 4),
                        $urandom_range(0, 4), $urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(1850);
        i_in_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_status_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/bsa_pkg.sv
sv/bsa_row_ram.sv
sv/bankers_safe_allocator.sv
dv/tb_bankers_safe_allocator.sv
